/* sv/des_pkg.sv */
package des_pkg;

  localparam int NumRounds = 16;

  typedef logic [63:0] blk_t;
  typedef logic [47:0] subkey_t;
  typedef logic [27:0] half_t;

  localparam logic [7:0] TabIp [64] = '{
    8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
    8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,  8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
    8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7
  };

  localparam logic [7:0] TabFp [64] = '{
    8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
    8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
    8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
    8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25
  };

  localparam logic [7:0] TabE [48] = '{
    8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
    8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
    8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
    8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1
  };

  localparam logic [7:0] TabP [32] = '{
    8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
    8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,    8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25
  };

  localparam logic [7:0] TabPc1 [56] = '{
    8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9, 8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
    8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27, 8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
    8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15, 8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
    8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29, 8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4
  };

  localparam logic [7:0] TabPc2 [48] = '{
    8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
    8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
    8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
    8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32
  };

  localparam logic [1:0] TabRot [16] = '{
    2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1
  };

  localparam logic [3:0] TabSbox [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  function automatic blk_t perm_ip(blk_t src);
    blk_t acc;
    for (int i = 0; i < 64; i++) acc[63-i] = src[64 - int'(TabIp[i])];
    return acc;
  endfunction

  function automatic blk_t perm_fp(blk_t src);
    blk_t acc;
    for (int i = 0; i < 64; i++) acc[63-i] = src[64 - int'(TabFp[i])];
    return acc;
  endfunction

  function automatic logic [55:0] perm_pc1(blk_t src);
    logic [55:0] acc;
    for (int i = 0; i < 56; i++) acc[55-i] = src[64 - int'(TabPc1[i])];
    return acc;
  endfunction

  function automatic subkey_t perm_pc2(logic [55:0] src);
    subkey_t acc;
    for (int i = 0; i < 48; i++) acc[47-i] = src[56 - int'(TabPc2[i])];
    return acc;
  endfunction

  function automatic half_t rot28(half_t v, logic [1:0] s);
    half_t res;
    if (s == 2'd2) res = {v[25:0], v[27:26]};
    else res = {v[26:0], v[27]};
    return res;
  endfunction

  function automatic logic [31:0] round_f(logic [31:0] r, subkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0] b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = TabSbox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TabP[i])];
    return p;
  endfunction

endpackage

/* sv/des_block_cipher_top.sv */
// throughput: one word per cycle; a stall freezes the whole pipeline
// stages: ip, sixteen rounds (one round each), final permutation
// subkeys are computed from the cfg_cipher_key input into a register set on config write
// reset: synchronous active-low rst_n clears valid bits and the subkey registers to zero
module des_block_cipher_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  des_pkg::blk_t        in_data_block,
  input  logic                 in_decrypt_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output des_pkg::blk_t        out_result_block,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  des_pkg::blk_t        cfg_cipher_key
);
  import des_pkg::*;

  localparam int NumStages = NumRounds + 2;

  subkey_t sub_r [NumRounds];
  subkey_t sub_nxt [NumRounds];
  logic [NumStages-1:0] vld_r;
  logic [31:0] l_r [NumRounds+1];
  logic [31:0] rr_r [NumRounds+1];
  logic dec_r [NumRounds+1];
  blk_t out_r;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NumStages-1];
  assign out_result_block = out_r;

  always_comb begin
    logic [55:0] k56;
    half_t c;
    half_t d;
    k56 = perm_pc1(cfg_cipher_key);
    c = k56[55:28];
    d = k56[27:0];
    for (int r = 0; r < NumRounds; r++) begin
      c = rot28(c, TabRot[r]);
      d = rot28(d, TabRot[r]);
      sub_nxt[r] = perm_pc2({c, d});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NumRounds; r++) sub_r[r] <= '0;
    end else if (cfg_valid) begin
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NumStages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {l_r[0], rr_r[0]} <= perm_ip(in_data_block);
      dec_r[0] <= in_decrypt_mode;
      for (int n = 0; n < NumRounds; n++) begin
        l_r[n+1] <= rr_r[n];
        rr_r[n+1] <= l_r[n] ^ round_f(rr_r[n], dec_r[n] ? sub_r[NumRounds-1-n] : sub_r[n]);
        dec_r[n+1] <= dec_r[n];
      end
      out_r <= perm_fp({rr_r[NumRounds], l_r[NumRounds]});
    end
  end

endmodule

/* sv/des_block_cipher_chk.sv */
module des_block_cipher_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input des_pkg::blk_t out_result_block
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("output dropped while stalled");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_block)) else $error("output changed");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("input stalled without output stall");
  a_no_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");
endmodule

bind des_block_cipher_top des_block_cipher_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_result_block(out_result_block)
);
